[rtl/ins_pkg.sv]
package ins_pkg;

  // default store size and value width
  localparam int CAPACITY_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // width of the sample and result ports
  localparam int PORT_BITS = 32;

  // width of the staging word used for extending or trimming values
  localparam int WIDE_BITS = 64;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_INSERT = 2'b01,
    ST_DRAIN  = 2'b10
  } state_t;

endpackage

[rtl/insertion_sorter.sv]
// Stable ascending insertion sorter. Values arrive one per transaction and are
// inserted into a row of compare-and-shift cells, one value per clock, behind
// every stored value that is not greater. The transaction with batch_end set
// closes the batch: the row then drains smallest first, one result per clock
// while result_ready stays high, with run_end on the largest value and the
// store is empty again for the next batch. Values that arrive while all
// CAPACITY cells are full are dropped and every result of that batch carries
// overflowed. Only the low VALUE_BITS bits of sample_value count, read as
// signed; sorted_value returns those bits zero-extended to 32. Throughput is
// one input per cycle while a batch fills; while the stored values of a batch
// drain, a two-entry queue in front of the cell row takes up to two further
// inputs before item_ready drops.
module insertion_sorter #(
  parameter int CAPACITY   = ins_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ins_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic signed [ins_pkg::PORT_BITS-1:0] sample_value,
  input  logic                                 batch_end,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic signed [ins_pkg::PORT_BITS-1:0] sorted_value,
  output logic                                 run_end,
  output logic                                 overflowed
);

  logic                  q_valid;
  logic                  q_ready;
  logic [VALUE_BITS-1:0] q_key;
  logic                  q_last;

  ins_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .sample_value (sample_value),
    .batch_end    (batch_end),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_key        (q_key),
    .q_last       (q_last)
  );

  ins_back #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_key        (q_key),
    .q_last       (q_last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sorted_value (sorted_value),
    .run_end      (run_end),
    .overflowed   (overflowed)
  );

endmodule

[rtl/ins_front.sv]
module ins_front #(
  parameter int VALUE_BITS = ins_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic signed [ins_pkg::PORT_BITS-1:0] sample_value,
  input  logic                                batch_end,
  output logic                                q_valid,
  input  logic                                q_ready,
  output logic [VALUE_BITS-1:0]               q_key,
  output logic                                q_last
);

  localparam int QD = ins_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int FW = $clog2(QD + 1);
  localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [VALUE_BITS-1:0] keys [QD];
  logic [QD-1:0]         lasts;
  logic [PW-1:0]         wr_ptr;
  logic [PW-1:0]         rd_ptr;
  logic [FW-1:0]         fill;

  logic [ins_pkg::WIDE_BITS-1:0] wide;
  logic [VALUE_BITS-1:0]         new_key;
  logic                          push;
  logic                          pop;

  // offset-binary key: unsigned order of keys equals signed order of values
  always_comb begin
    wide    = ins_pkg::WIDE_BITS'($unsigned(sample_value));
    new_key = wide[VALUE_BITS-1:0] ^ SIGN_BIT;
  end

  assign item_ready = (fill != FW'(QD));
  assign q_valid    = (fill != '0);
  assign q_key      = keys[rd_ptr];
  assign q_last     = lasts[rd_ptr];
  assign push       = item_valid && item_ready;
  assign pop        = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        keys[wr_ptr]  <= new_key;
        lasts[wr_ptr] <= batch_end;
        wr_ptr        <= (wr_ptr == PW'(QD - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QD - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[rtl/ins_back.sv]
module ins_back #(
  parameter int CAPACITY   = ins_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ins_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  output logic                                 q_ready,
  input  logic [VALUE_BITS-1:0]                q_key,
  input  logic                                 q_last,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic signed [ins_pkg::PORT_BITS-1:0] sorted_value,
  output logic                                 run_end,
  output logic                                 overflowed
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

  ins_pkg::state_t state;

  logic [VALUE_BITS-1:0] cells      [CAPACITY];
  logic [VALUE_BITS-1:0] cells_next [CAPACITY];
  logic [CAPACITY-1:0]   gtx;
  logic [CW-1:0]         count;
  logic                  drop;
  logic                  load;

  logic [ins_pkg::WIDE_BITS-1:0] head_wide;

  // each cell decides on its own: take the left neighbor, the new key, or hold
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gtx[i] = (CW'(i) >= count) || (cells[i] > q_key);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (i > 0 && gtx[(i > 0) ? i - 1 : 0]) begin
        cells_next[i] = cells[(i > 0) ? i - 1 : 0];
      end else if (gtx[i]) begin
        cells_next[i] = q_key;
      end else begin
        cells_next[i] = cells[i];
      end
    end
  end

  always_comb begin
    head_wide = ins_pkg::WIDE_BITS'(cells[0] ^ SIGN_BIT);
  end

  assign q_ready = (state == ins_pkg::ST_INSERT);
  assign load    = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ins_pkg::ST_INSERT;
      count        <= '0;
      drop         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        ins_pkg::ST_INSERT: begin
          // the final result of the last batch may still be waiting here
          if (result_valid && result_ready) begin
            result_valid <= 1'b0;
          end
          if (q_valid) begin
            if (count < CW'(CAPACITY)) begin
              for (int i = 0; i < CAPACITY; i++) begin
                cells[i] <= cells_next[i];
              end
              count <= count + 1'b1;
            end else begin
              drop <= 1'b1;
            end
            if (q_last) begin
              state <= ins_pkg::ST_DRAIN;
            end
          end
        end
        ins_pkg::ST_DRAIN: begin
          // smallest value sits in cell 0; the row shifts down once per result
          if (load) begin
            result_valid <= 1'b1;
            sorted_value <= $signed(head_wide[ins_pkg::PORT_BITS-1:0]);
            run_end      <= (count == CW'(1));
            overflowed   <= drop;
            for (int i = 0; i < CAPACITY - 1; i++) begin
              cells[i] <= cells[i + 1];
            end
            count <= count - 1'b1;
            if (count == CW'(1)) begin
              state <= ins_pkg::ST_INSERT;
              drop  <= 1'b0;
            end
          end
        end
        default: begin
          state <= ins_pkg::ST_INSERT;
        end
      endcase
    end
  end

endmodule

[verif/tb_insertion_sorter.sv]
`timescale 1ns / 100ps

module tb_insertion_sorter;

  localparam int SLOTS       = ins_pkg::CAPACITY_DEF;
  localparam int VBITS       = ins_pkg::PORT_BITS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 80;
  localparam int RANDOM_ITEMS = 160;

  typedef struct {
    logic signed [VBITS-1:0] value;
    logic                    last;
    bit                      hold;
  } sample_t;

  typedef struct {
    logic signed [VBITS-1:0] value;
    logic                    last;
    logic                    dropped;
  } sorted_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    item_valid = 1'b0;
  logic                    item_ready;
  logic signed [VBITS-1:0] sample_value = '0;
  logic                    batch_end = 1'b0;
  logic                    result_valid;
  logic                    result_ready = 1'b0;
  logic signed [VBITS-1:0] sorted_value;
  logic                    run_end;
  logic                    overflowed;

  sample_t pending_samples[$];
  sorted_t sorted_due[$];

  // shadow of the block's store
  logic signed [VBITS-1:0] shadow_store [SLOTS];
  int                      shadow_fill = 0;
  bit                      shadow_dropped = 0;

  int  error_count = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  bit  quiet = 0;

  insertion_sorter uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .sample_value (sample_value),
    .batch_end    (batch_end),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sorted_value (sorted_value),
    .run_end      (run_end),
    .overflowed   (overflowed)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stretches with no idling at all
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) begin
      quiet <= !quiet;
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    if (error_count <= 50) begin
      $display("[%0t] mismatch %s: got %0d want %0d", $time, what, got, want);
    end
  endtask

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // stable insert behind every stored value not greater; a closing
  // transaction releases the whole store in order
  task automatic insert_sample(logic signed [VBITS-1:0] value, logic last);
    int      pos;
    sorted_t res;
    if (shadow_fill < SLOTS) begin
      pos = shadow_fill;
      while (pos > 0 && shadow_store[pos-1] > value) begin
        shadow_store[pos] = shadow_store[pos-1];
        pos--;
      end
      shadow_store[pos] = value;
      shadow_fill++;
    end else begin
      shadow_dropped = 1;
    end
    if (last) begin
      for (int k = 0; k < shadow_fill; k++) begin
        res.value   = shadow_store[k];
        res.last    = (k == shadow_fill - 1);
        res.dropped = shadow_dropped;
        sorted_due.push_back(res);
      end
      shadow_fill = 0;
      shadow_dropped = 0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    sample_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        insert_sample(sample_value, batch_end);
      end
      if (!(item_valid && !item_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (pending_samples.size() > 0 &&
                     !(pending_samples[0].hold && sorted_due.size() > 0)) begin
          nxt = pending_samples.pop_front();
          item_valid   <= 1'b1;
          sample_value <= nxt.value;
          batch_end    <= nxt.last;
          send_gap = pick_idle();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    sorted_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (sorted_due.size() == 0) begin
          report_mismatch("unexpected result, value", sorted_value, 0);
        end else begin
          want = sorted_due.pop_front();
          if (sorted_value !== want.value)
            report_mismatch("sorted_value", sorted_value, want.value);
          if (run_end !== want.last)
            report_mismatch("run_end", run_end, want.last);
          if (overflowed !== want.dropped)
            report_mismatch("overflowed", overflowed, want.dropped);
        end
        recv_stall = pick_idle();
      end
      if (recv_stall > 0) begin
        recv_stall--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  task automatic push_sample(logic signed [VBITS-1:0] value, logic last, bit hold = 0);
    sample_t s;
    s.value = value;
    s.last  = last;
    s.hold  = hold;
    pending_samples.push_back(s);
  endtask

  function automatic logic signed [VBITS-1:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom;
    if (r < 8) return $signed($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh7ffffffe;
      3: return 32'sh80000001;
      4: return -1;
      default: return 0;
    endcase
  endfunction

  task automatic push_batch(int count, bit hold);
    for (int i = 0; i < count; i++) begin
      push_sample(rand_value(), i == count - 1, hold && i == 0);
    end
  endtask

  initial begin
    int queued;
    int size;

    // extremes in mixed order
    push_sample(32'sh7fffffff, 1'b0);
    push_sample(32'sh80000000, 1'b0);
    push_sample(0, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(1, 1'b1);
    // single-value batches
    push_sample(32'sh80000000, 1'b1);
    push_sample(32'sh7fffffff, 1'b1, 1'b1);
    // duplicates keep arrival order
    push_sample(3, 1'b0);
    push_sample(-3, 1'b0);
    push_sample(3, 1'b0);
    push_sample(3, 1'b0);
    push_sample(-3, 1'b1);
    // descending then ascending
    for (int i = 0; i < 5; i++) push_sample(100 - i * 40, i == 4);
    for (int i = 0; i < 5; i++) push_sample(-100 + i * 40, i == 4);

    // full store without drop, then batches that close on a dropped value
    push_batch(SLOTS, 1'b1);
    push_batch(SLOTS + 1, 1'b0);
    push_batch(SLOTS + 3, 1'b1);
    queued = pending_samples.size();
    while (queued < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) size = $urandom_range(SLOTS - 4, SLOTS + 4);
      else size = $urandom_range(1, 8);
      push_batch(size, $urandom_range(0, 5) == 0);
      queued += size;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_samples.size() > 0 || item_valid || sorted_due.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sorted_due.size() != 0)
      report_mismatch("results left over", sorted_due.size(), 0);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ins_pkg.sv
rtl/ins_front.sv
rtl/ins_back.sv
rtl/insertion_sorter.sv
verif/tb_insertion_sorter.sv
